// ----- rtl/core/sel_pkg.sv -----
// types, codes and sizes shared by the latch table files
package sel_pkg;

   localparam int NUM_LATCHES  = 256;
   localparam int LATCH_BITS   = $clog2(NUM_LATCHES);
   localparam int SESSION_BITS = 16;
   localparam int COUNT_BITS   = 16;

   // field widths of the channels
   localparam int OPCODE_W  = 3;
   localparam int INDEX_W   = 8;
   localparam int SESSION_W = 16;
   localparam int STATUS_W  = 3;
   localparam int MODE_W    = 2;
   localparam int OWNER_W   = 16;
   localparam int READERS_W = 16;

   // latch mode codes, as stored
   localparam logic [MODE_W-1:0] MODE_SHARED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_EXCL   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEND   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BAD    = 2'd3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_READ      = 3'd0,
      OP_WRITE     = 3'd1,
      OP_DIRECT_X  = 3'd2,
      OP_UNLOCK    = 3'd3,
      OP_RECOVER   = 3'd4,
      OP_FORCE     = 3'd5,
      OP_CLEAN_BEG = 3'd6,
      OP_CLEAN_END = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 3'd0,
      ST_WAIT  = 3'd1,
      ST_BUSY  = 3'd2,
      ST_CLEAN = 3'd3,
      ST_FAIL  = 3'd4
   } status_type;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [SESSION_BITS-1:0] owner;
      logic [COUNT_BITS-1:0]   readers;
      logic [COUNT_BITS-1:0]   cleanup;
   } entry_type;

endpackage

// ----- rtl/core/sel_if.sv -----
// request and response channel interfaces of the latch table
interface sel_req_if import sel_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic [INDEX_W-1:0]   latch_index;
   logic [SESSION_W-1:0] session;
   logic                 recover_mode;

   modport source (output valid, opcode, latch_index, session, recover_mode, input ready);
   modport sink   (input valid, opcode, latch_index, session, recover_mode, output ready);
endinterface

interface sel_rsp_if import sel_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [MODE_W-1:0]    mode_after;
   logic [OWNER_W-1:0]   owner_after;
   logic [READERS_W-1:0] readers_after;

   modport source (output valid, status, mode_after, owner_after, readers_after, input ready);
   modport sink   (input valid, status, mode_after, owner_after, readers_after, output ready);
endinterface

// ----- rtl/core/shared_exclusive_latch_table_top.sv -----
// shared/exclusive latch table: entry memory, read-modify-write stage and response register
//
//  channel   direction  handshake      payload
//  req_ch    in         valid/ready    opcode, latch_index, session, recover_mode
//  rsp_ch    out        valid/ready    status, mode_after, owner_after, readers_after
//
// one item a cycle sustained while rsp_ch is ready; a taken request passes the modify stage, then the response register
// the rate is set by the entry memory: read on accept, modify and write back when the modify stage retires
// a request taken as its entry is being written back takes the forwarded copy, no stall
// reset clears one valid flag per entry at once, so entries read as unlocked without a sweep
// a stalled response holds the modify stage, which in turn holds off new requests
module shared_exclusive_latch_table_top
   import sel_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   sel_req_if.sink   req_ch,
   sel_rsp_if.source rsp_ch
);

   // entry memory and per-entry valid flags
   entry_type                 mem [NUM_LATCHES];
   logic [NUM_LATCHES-1:0]    vld_ff;

   // modify stage: request and registered memory read
   logic                      s1_valid_ff;
   op_type                    s1_op_ff;
   logic [LATCH_BITS-1:0]     s1_idx_ff;
   logic                      s1_range_ff;
   logic [SESSION_BITS-1:0]   s1_sess_ff;
   logic                      s1_rm_ff;
   entry_type                 rd_data_ff;
   logic                      rd_vld_ff;

   // copy of the last write, for a read that overlapped it
   logic                      fwd_vld_ff;
   logic [LATCH_BITS-1:0]     fwd_idx_ff;
   entry_type                 fwd_data_ff;

   // response register
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [MODE_W-1:0]         rsp_mode_ff;
   logic [OWNER_W-1:0]        rsp_owner_ff;
   logic [READERS_W-1:0]      rsp_readers_ff;

   logic                      req_take;
   logic                      s1_adv;
   logic                      wr_en;
   logic [LATCH_BITS-1:0]     req_idx;
   entry_type                 cur;
   entry_type                 nxt;
   status_type                st;
   logic                      cln;
   logic                      unlocked;
   logic                      own;

   // handshake: stage moves on when the response slot is free or being emptied
   assign s1_adv       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign req_idx      = req_ch.latch_index[LATCH_BITS-1:0];
   assign wr_en        = s1_valid_ff && s1_adv && s1_range_ff;

   // memory port: read on accept, write back when the modify stage retires
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_data_ff <= mem[req_idx];
      end
      if (wr_en) begin
         mem[s1_idx_ff] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[s1_idx_ff] <= 1'b1;
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            fwd_vld_ff <= 1'b1;
         end
         if (s1_valid_ff && s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload of the stage, response and forward copy: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= op_type'(req_ch.opcode);
         s1_idx_ff   <= req_idx;
         s1_range_ff <= ({1'b0, req_ch.latch_index} < (INDEX_W + 1)'(NUM_LATCHES));
         s1_sess_ff  <= req_ch.session[SESSION_BITS-1:0];
         s1_rm_ff    <= req_ch.recover_mode;
         rd_vld_ff   <= vld_ff[req_idx];
      end
      if (wr_en) begin
         fwd_idx_ff  <= s1_idx_ff;
         fwd_data_ff <= nxt;
      end
      if (s1_valid_ff && s1_adv) begin
         rsp_status_ff <= STATUS_W'(st);
         if (s1_range_ff) begin
            rsp_mode_ff    <= nxt.mode;
            rsp_owner_ff   <= OWNER_W'(nxt.owner);
            rsp_readers_ff <= READERS_W'(nxt.readers);
         end else begin
            rsp_mode_ff    <= '0;
            rsp_owner_ff   <= '0;
            rsp_readers_ff <= '0;
         end
      end
   end

   // current entry: never-written entries read as unlocked, last write forwarded
   always_comb begin
      cur = rd_vld_ff ? rd_data_ff : '0;
      if (fwd_vld_ff && fwd_idx_ff == s1_idx_ff) begin
         cur = fwd_data_ff;
      end
   end

   assign cln      = cur.cleanup != '0;
   assign unlocked = cur.mode == MODE_SHARED && cur.owner == '0 && cur.readers == '0;
   assign own      = cur.owner == s1_sess_ff;

   // opcode decode and entry update
   always_comb begin
      nxt = cur;
      st  = ST_OK;
      case (s1_op_ff)
         OP_READ: begin
            if (cln) begin
               st = ST_CLEAN;
            end else if (cur.mode == MODE_SHARED && cur.readers != '1) begin
               nxt.readers = cur.readers + 1'b1;
            end else begin
               st = ST_BUSY;
            end
         end
         OP_WRITE: begin
            if (cln) begin
               st = ST_CLEAN;
            end else if (unlocked) begin
               nxt.mode    = MODE_EXCL;
               nxt.owner   = s1_sess_ff;
               nxt.readers = '0;
            end else if (cur.mode == MODE_SHARED) begin
               // readers still in: mark pending so no new reader gets in
               nxt.mode  = MODE_PEND;
               nxt.owner = s1_sess_ff;
               st        = ST_WAIT;
            end else if (cur.mode == MODE_PEND && own) begin
               if (cur.readers == '0) begin
                  nxt.mode    = MODE_EXCL;
                  nxt.owner   = s1_sess_ff;
                  nxt.readers = '0;
               end else begin
                  st = ST_WAIT;
               end
            end else begin
               st = ST_BUSY;
            end
         end
         OP_DIRECT_X: begin
            if (cln) begin
               st = ST_CLEAN;
            end else if (unlocked) begin
               nxt.mode    = MODE_EXCL;
               nxt.owner   = s1_sess_ff;
               nxt.readers = '0;
            end else begin
               st = ST_BUSY;
            end
         end
         OP_UNLOCK: begin
            if (cur.mode == MODE_SHARED || cur.mode == MODE_PEND) begin
               if (cur.readers != '0) begin
                  nxt.readers = cur.readers - 1'b1;
               end else begin
                  nxt.mode  = MODE_SHARED;
                  nxt.owner = '0;
               end
            end else if (cur.mode == MODE_EXCL && own) begin
               nxt.mode    = MODE_SHARED;
               nxt.owner   = '0;
               nxt.readers = '0;
            end else begin
               st = ST_FAIL;
            end
         end
         OP_RECOVER: begin
            if (cur.mode == MODE_BAD) begin
               st = ST_FAIL;
            end else if (!s1_rm_ff) begin
               if (cur.mode != MODE_EXCL && cur.readers != '0) begin
                  nxt.readers = cur.readers - 1'b1;
               end
            end else if (cur.mode != MODE_SHARED && own) begin
               nxt.mode  = MODE_SHARED;
               nxt.owner = '0;
               if (cur.mode == MODE_EXCL) begin
                  nxt.readers = '0;
               end
            end
         end
         OP_FORCE: begin
            nxt.mode    = MODE_SHARED;
            nxt.owner   = '0;
            nxt.readers = '0;
         end
         OP_CLEAN_BEG: begin
            if (cur.cleanup != '1) begin
               nxt.cleanup = cur.cleanup + 1'b1;
            end
         end
         OP_CLEAN_END: begin
            if (cln) begin
               nxt.cleanup = cur.cleanup - 1'b1;
            end
         end
         default: begin
            st = ST_FAIL;
         end
      endcase
      if (!s1_range_ff) begin
         st = ST_FAIL;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.mode_after    = rsp_mode_ff;
   assign rsp_ch.owner_after   = rsp_owner_ff;
   assign rsp_ch.readers_after = rsp_readers_ff;

   // mode code 3 is never written back
   a_no_bad_mode: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> nxt.mode != MODE_BAD)
      else $error("bad mode code written to latch entry");

   // an exclusive latch never carries readers
   a_excl_no_readers: assert property (@(posedge clock) disable iff (reset)
      wr_en && nxt.mode == MODE_EXCL |-> nxt.readers == '0)
      else $error("exclusive latch written with readers");

   // the forward copy tracks the latest write-back
   a_fwd_tracks: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> fwd_vld_ff && fwd_idx_ff == $past(s1_idx_ff))
      else $error("forward copy lost the last write");

   // a stalled modify stage keeps its item
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_idx_ff))
      else $error("modify stage dropped a stalled item");

endmodule

// ----- bench/tb_latch_table_checker.sv -----
// latch table checker: predicts each response from the accepted requests and compares them
`timescale 1ns / 1ps

module tb_latch_table_checker
   import sel_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sel_req_if          req_mon,
   sel_rsp_if          rsp_mon,
   output int unsigned error_count,
   output int unsigned outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [MODE_W-1:0]    mode;
      logic [OWNER_W-1:0]   owner;
      logic [READERS_W-1:0] readers;
   } latch_result_type;

   // shadow copy of the latch table
   logic [MODE_W-1:0]       mode_tab    [NUM_LATCHES];
   logic [SESSION_BITS-1:0] owner_tab   [NUM_LATCHES];
   logic [COUNT_BITS-1:0]   readers_tab [NUM_LATCHES];
   logic [COUNT_BITS-1:0]   clean_tab   [NUM_LATCHES];

   latch_result_type expected_rsp_q[$];
   int unsigned      err_total = 0;
   int unsigned      reported  = 0;

   function automatic void clear_entry(input int i);
      mode_tab[i]    = MODE_SHARED;
      owner_tab[i]   = '0;
      readers_tab[i] = '0;
   endfunction

   function automatic void take_exclusive(input int i, input logic [SESSION_BITS-1:0] s);
      mode_tab[i]    = MODE_EXCL;
      owner_tab[i]   = s;
      readers_tab[i] = '0;
   endfunction

   // one read-modify-write of the named latch, returns the response it gives
   function automatic latch_result_type apply_request(input op_type op,
                                                      input logic [INDEX_W-1:0] idx,
                                                      input logic [SESSION_W-1:0] sess,
                                                      input logic rmode);
      latch_result_type        r;
      int                      i;
      logic [MODE_W-1:0]       m;
      logic [SESSION_BITS-1:0] s;
      logic                    unlocked;
      logic                    cleaning;
      r        = '0;
      r.status = ST_OK;
      i        = int'(idx);
      if (i >= NUM_LATCHES) begin
         r.status = ST_FAIL;
         return r;
      end
      s        = sess[SESSION_BITS-1:0];
      m        = mode_tab[i];
      unlocked = (m == MODE_SHARED) && (owner_tab[i] == '0) && (readers_tab[i] == '0);
      cleaning = (clean_tab[i] != '0);
      case (op)
         OP_READ: begin
            if (cleaning) r.status = ST_CLEAN;
            else if (m == MODE_SHARED && readers_tab[i] != {COUNT_BITS{1'b1}})
               readers_tab[i] = readers_tab[i] + 1'b1;
            else r.status = ST_BUSY;
         end
         OP_WRITE: begin
            if (cleaning) r.status = ST_CLEAN;
            else if (unlocked) take_exclusive(i, s);
            else if (m == MODE_SHARED) begin
               mode_tab[i]  = MODE_PEND;
               owner_tab[i] = s;
               r.status     = ST_WAIT;
            end else if (m == MODE_PEND && owner_tab[i] == s) begin
               if (readers_tab[i] == '0) take_exclusive(i, s);
               else r.status = ST_WAIT;
            end else r.status = ST_BUSY;
         end
         OP_DIRECT_X: begin
            if (cleaning) r.status = ST_CLEAN;
            else if (unlocked) take_exclusive(i, s);
            else r.status = ST_BUSY;
         end
         OP_UNLOCK: begin
            if (m == MODE_SHARED || m == MODE_PEND) begin
               if (readers_tab[i] != '0) readers_tab[i] = readers_tab[i] - 1'b1;
               else clear_entry(i);
            end else if (m == MODE_EXCL && owner_tab[i] == s) clear_entry(i);
            else r.status = ST_FAIL;
         end
         OP_RECOVER: begin
            if (m == MODE_BAD) r.status = ST_FAIL;
            else if (!rmode) begin
               if (m != MODE_EXCL && readers_tab[i] != '0)
                  readers_tab[i] = readers_tab[i] - 1'b1;
            end else if (m != MODE_SHARED && owner_tab[i] == s) begin
               if (m == MODE_EXCL) clear_entry(i);
               else begin
                  mode_tab[i]  = MODE_SHARED;
                  owner_tab[i] = '0;
               end
            end
         end
         OP_FORCE: clear_entry(i);
         OP_CLEAN_BEG: begin
            if (clean_tab[i] != {COUNT_BITS{1'b1}}) clean_tab[i] = clean_tab[i] + 1'b1;
         end
         default: begin
            if (cleaning) clean_tab[i] = clean_tab[i] - 1'b1;
         end
      endcase
      r.mode    = mode_tab[i];
      r.owner   = OWNER_W'(owner_tab[i]);
      r.readers = READERS_W'(readers_tab[i]);
      return r;
   endfunction

   always @(posedge clock) begin
      latch_result_type got;
      latch_result_type want;
      if (reset) begin
         for (int i = 0; i < NUM_LATCHES; i++) begin
            clear_entry(i);
            clean_tab[i] = '0;
         end
         expected_rsp_q.delete();
      end else begin
         // responses first: a request taken at this edge cannot answer at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.status, rsp_mon.mode_after, rsp_mon.owner_after,
                   rsp_mon.readers_after};
            if (expected_rsp_q.size() == 0) begin
               err_total++;
               if (reported < 10) begin
                  reported++;
                  $display("%0t: unexpected response: status %0d mode %0d owner %h readers %0d",
                           $time, got.status, got.mode, got.owner, got.readers);
               end
            end else begin
               want = expected_rsp_q.pop_front();
               if (got !== want) begin
                  err_total++;
                  if (reported < 10) begin
                     reported++;
                     $write("%0t: mismatch: expected status %0d mode %0d owner %h readers %0d",
                            $time, want.status, want.mode, want.owner, want.readers);
                     $display("; got status %0d mode %0d owner %h readers %0d",
                              got.status, got.mode, got.owner, got.readers);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsp_q.push_back(apply_request(op_type'(req_mon.opcode),
                                                   req_mon.latch_index, req_mon.session,
                                                   req_mon.recover_mode));
      end
      error_count <= err_total;
      outstanding <= expected_rsp_q.size();
   end

endmodule

// ----- bench/tb_shared_exclusive_latch_table_top.sv -----
// latch table testbench top: clock, reset, request stimulus, response stalls and the verdict
`timescale 1ns / 1ps

module tb_shared_exclusive_latch_table_top
   import sel_pkg::*;
();

   // two sessions that the directed part plays against each other
   localparam logic [SESSION_W-1:0] SESS_A = 16'h1234;
   localparam logic [SESSION_W-1:0] SESS_B = 16'hFFFF;

   typedef struct {
      op_type                op;
      logic [INDEX_W-1:0]    idx;
      logic [SESSION_W-1:0]  sess;
      logic                  rmode;
      bit                    tight;   // sent with no gaps
   } latch_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sel_req_if req_ch ();
   sel_rsp_if rsp_ch ();

   latch_req_type stim_q[$];
   bit            build_tight = 1'b0;
   bit            sent_all    = 1'b0;
   int unsigned   error_count;
   int unsigned   outstanding;

   shared_exclusive_latch_table_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tb_latch_table_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic push_req(input op_type op, input logic [INDEX_W-1:0] idx,
                           input logic [SESSION_W-1:0] sess, input logic rmode);
      latch_req_type it;
      it.op    = op;
      it.idx   = idx;
      it.sess  = sess;
      it.rmode = rmode;
      it.tight = build_tight;
      stim_q.push_back(it);
   endtask

   // mostly a handful of hot latches so that contention builds up, now and then any latch
   function automatic logic [INDEX_W-1:0] pick_latch();
      if ($urandom_range(0, 7) == 0) return INDEX_W'($urandom);
      return INDEX_W'($urandom_range(0, 5));
   endfunction

   // a small pool of sessions, the extremes among them, or any session
   function automatic logic [SESSION_W-1:0] pick_session();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'h0001;
         2: return 16'h8000;
         3: return '1;
         4: return SESS_A;
         default: return SESSION_W'($urandom);
      endcase
   endfunction

   // stimulus is built up front; the sender only starts once reset is over
   initial begin : build_stimulus
      logic [INDEX_W-1:0]   idx;
      logic [SESSION_W-1:0] s;
      logic [SESSION_W-1:0] s2;
      int                   k;

      // directed part goes back to back so that the same latch is hit every cycle the uut is ready
      build_tight = 1'b1;

      // writer preference on latch 0: readers in, a writer waits, readers drain
      push_req(OP_READ,     8'd0, SESS_A, 1'b0);
      push_req(OP_READ,     8'd0, SESS_B, 1'b1);
      push_req(OP_WRITE,    8'd0, SESS_A, 1'b0);   // pending, waiting for readers
      push_req(OP_READ,     8'd0, SESS_B, 1'b0);   // busy while a writer waits
      push_req(OP_WRITE,    8'd0, SESS_B, 1'b0);   // pending for someone else
      push_req(OP_UNLOCK,   8'd0, SESS_B, 1'b0);
      push_req(OP_WRITE,    8'd0, SESS_A, 1'b1);   // still one reader
      push_req(OP_UNLOCK,   8'd0, '0,     1'b0);
      push_req(OP_WRITE,    8'd0, SESS_A, 1'b0);   // now exclusive
      push_req(OP_DIRECT_X, 8'd0, SESS_B, 1'b0);
      push_req(OP_UNLOCK,   8'd0, SESS_B, 1'b0);   // foreign exclusive unlock fails
      push_req(OP_RECOVER,  8'd0, SESS_B, 1'b1);   // other owner, no change
      push_req(OP_RECOVER,  8'd0, SESS_A, 1'b0);   // shared recovery of exclusive, no change
      push_req(OP_UNLOCK,   8'd0, SESS_A, 1'b0);
      push_req(OP_UNLOCK,   8'd0, SESS_A, 1'b0);   // unlock of an already free latch

      // top latch, session zero owning it exclusively
      push_req(OP_DIRECT_X, 8'd255, '0, 1'b1);
      push_req(OP_READ,     8'd255, '1, 1'b0);
      push_req(OP_FORCE,    8'd255, '1, 1'b1);

      // cleanup refuses acquisitions, end is clamped at zero
      push_req(OP_CLEAN_BEG, 8'd1, SESS_A, 1'b0);
      push_req(OP_READ,      8'd1, SESS_A, 1'b0);
      push_req(OP_WRITE,     8'd1, SESS_A, 1'b0);
      push_req(OP_DIRECT_X,  8'd1, SESS_A, 1'b0);
      push_req(OP_CLEAN_END, 8'd1, SESS_A, 1'b0);
      push_req(OP_CLEAN_END, 8'd1, SESS_A, 1'b1);
      push_req(OP_READ,      8'd1, SESS_A, 1'b0);

      // recovery of a pending writer returns to shared, readers kept and floored
      push_req(OP_READ,    8'd2, SESS_A, 1'b0);
      push_req(OP_WRITE,   8'd2, SESS_B, 1'b0);
      push_req(OP_RECOVER, 8'd2, SESS_B, 1'b1);
      push_req(OP_RECOVER, 8'd2, SESS_B, 1'b0);
      push_req(OP_RECOVER, 8'd2, SESS_B, 1'b0);

      build_tight = 1'b0;

      // random part: mostly lock and unlock sequences with random content, some noise
      while (stim_q.size() < 1350) begin
         idx = pick_latch();
         s   = pick_session();
         s2  = pick_session();
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               // readers come and go
               k = $urandom_range(1, 4);
               repeat (k) push_req(OP_READ, idx, pick_session(), 1'($urandom));
               repeat (k) push_req(OP_UNLOCK, idx, pick_session(), 1'($urandom));
            end
            3, 4: begin
               // a writer steps in against a reader
               push_req(OP_WRITE,  idx, s,  1'($urandom));
               push_req(OP_READ,   idx, s2, 1'($urandom));
               push_req(OP_UNLOCK, idx, s2, 1'($urandom));
               push_req(OP_WRITE,  idx, s,  1'($urandom));
               push_req(OP_WRITE,  idx, s,  1'($urandom));
               push_req(OP_UNLOCK, idx, s,  1'($urandom));
            end
            5: begin
               push_req(OP_DIRECT_X, idx, s, 1'($urandom));
               push_req(OP_UNLOCK, idx, ($urandom_range(0, 3) == 0) ? s2 : s, 1'($urandom));
            end
            6: begin
               push_req(OP_WRITE, idx, s, 1'($urandom));
               push_req(OP_RECOVER, idx, $urandom_range(0, 1) ? s : s2, 1'($urandom));
            end
            7: begin
               push_req(OP_CLEAN_BEG, idx, s, 1'($urandom));
               push_req(op_type'($urandom_range(0, 2)), idx, s2, 1'($urandom));
               push_req(OP_CLEAN_END, idx, s, 1'($urandom));
               if ($urandom_range(0, 1)) push_req(OP_CLEAN_END, idx, s, 1'($urandom));
            end
            8: push_req(OP_FORCE, idx, s, 1'($urandom));
            default: push_req(op_type'($urandom_range(0, 7)), INDEX_W'($urandom),
                              SESSION_W'($urandom), 1'($urandom));
         endcase
      end
   end

   // sender: bursts of random length with random gaps, items change at the falling edge
   initial begin : sender
      latch_req_type it;
      int            gap_left;
      int            burst_left;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = '0;
      req_ch.latch_index  = '0;
      req_ch.session      = '0;
      req_ch.recover_mode = 1'b0;
      gap_left   = 0;
      burst_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      while (stim_q.size() > 0) begin
         if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left--;
            @(negedge clock);
         end else begin
            it = stim_q.pop_front();
            req_ch.valid        <= 1'b1;
            req_ch.opcode       <= it.op;
            req_ch.latch_index  <= it.idx;
            req_ch.session      <= it.sess;
            req_ch.recover_mode <= it.rmode;
            @(posedge clock);
            while (!req_ch.ready) @(posedge clock);
            @(negedge clock);
            // valid stays up into the next item unless a gap starts here
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 40);
               if (!it.tight && $urandom_range(0, 3) != 0) gap_left = $urandom_range(1, 10);
            end
         end
      end
      req_ch.valid <= 1'b0;
      sent_all = 1'b1;
   end

   // receiver: a randomly redrawn stall pattern, plus two long hold-offs that back
   // the block up into its request port while the sender is still busy
   initial begin : receiver
      int unsigned cyc;
      int unsigned hold_left;
      int unsigned style;
      rsp_ch.ready = 1'b0;
      cyc       = 0;
      hold_left = 0;
      style     = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 700 || cyc == 1800) hold_left = 180;
         if (cyc % 64 == 0) style = $urandom_range(0, 4);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (style)
               0, 1: rsp_ch.ready <= 1'b1;
               2:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               3:    rsp_ch.ready <= 1'($urandom);
               default: rsp_ch.ready <= ((cyc % 8) < 5);
            endcase
         end
      end
   end

   // reset, wait for all items and responses, then the verdict
   initial begin : verdict
      int drain;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (sent_all);
      drain = 0;
      while (outstanding != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      // give a margin for stray responses
      repeat (20) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("shared_exclusive_latch_table_top regression: pass");
      end else begin
         $display("shared_exclusive_latch_table_top regression: fail");
      end
      $finish;
   end

   // overall limit, far above the slowest correct run
   initial begin : run_limit
      #20_000_000;
      $display("shared_exclusive_latch_table_top regression: fail");
      $finish;
   end

endmodule
